// ----- src/brle_pkg.sv -----
// Shared types and constants of the BMP RLE8 decoder.
`default_nettype none
package brle_pkg;

	localparam int DimW = 13;
	localparam logic [DimW-1:0] MaxWidth  = 13'd4096;
	localparam logic [DimW-1:0] MaxHeight = 13'd4096;

	localparam int AddrW = 3;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		KIND_SPAN      = 2'd0,
		KIND_OK        = 2'd1,
		KIND_DELTA_CUT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_COUNT = 3'd0,
		PH_VALUE = 3'd1,
		PH_DX    = 3'd2,
		PH_DY    = 3'd3,
		PH_LIT   = 3'd4,
		PH_PAD   = 3'd5,
		PH_STOP  = 3'd6
	} phase_t;

	typedef struct packed {
		logic [DimW-1:0] width;
		logic [DimW-1:0] height;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [11:0] row;
		logic [11:0] column;
		logic [7:0]  span_length;
		logic [7:0]  pixel_value;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    res0;
		result_t    res1;
	} push_t;

endpackage
`default_nettype wire

// ----- src/brle_regs.sv -----
// APB configuration registers: image width and height.
`default_nettype none
module brle_regs (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire [brle_pkg::AddrW-1:0]  paddr,
	input  wire [31:0]                 pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output brle_pkg::cfg_t             cfg
);
	import brle_pkg::*;

	logic [DimW-1:0] width_q;
	logic [DimW-1:0] height_q;
	logic            wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd4096;
			height_q <= 13'd4096;
		end else if (wr_en) begin
			if (paddr[2] == REG_IMAGE_WIDTH) begin
				width_q <= pwdata[DimW-1:0];
			end else begin
				height_q <= pwdata[DimW-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_IMAGE_HEIGHT) begin
			prdata = {19'd0, height_q};
		end else begin
			prdata = {19'd0, width_q};
		end
	end

	assign cfg.width  = width_q;
	assign cfg.height = height_q;

endmodule
`default_nettype wire

// ----- src/brle_parse.sv -----
// Input register, parse state and per-byte result generation.
`default_nettype none
module brle_parse (
	input  wire             clk,
	input  wire             arst_n,
	input  brle_pkg::cfg_t  cfg,
	input  wire             in_valid,
	output logic            in_ready,
	input  wire [7:0]       byte_in,
	input  wire             end_of_stream,
	input  wire             space_ok,
	output brle_pkg::push_t push
);
	import brle_pkg::*;

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            eos_s1;
	logic            advance;

	phase_t          phase_q, phase_d;
	logic [DimW-1:0] col_q, col_d;
	logic [DimW-1:0] row_q, row_d;
	logic [7:0]      held_q, held_d;
	logic [7:0]      lit_q, lit_d;
	logic            pad_q, pad_d;

	logic [DimW-1:0] w, h, room;
	logic [DimW:0]   col_sum, row_sum;
	logic [7:0]      len;
	logic [7:0]      lit_dec;
	logic            span_hit;
	logic            delta_cut;
	result_t         span_res, fin_res;

	assign advance  = valid_s1 && space_ok;
	assign in_ready = !valid_s1 || space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
			eos_s1  <= end_of_stream;
		end
	end

	always_comb begin
		w        = (cfg.width > MaxWidth) ? MaxWidth : cfg.width;
		h        = (cfg.height > MaxHeight) ? MaxHeight : cfg.height;
		room     = w - col_q;
		len      = ({5'd0, held_q} < room) ? held_q : room[7:0];
		col_sum  = {1'b0, col_q} + {6'd0, byte_s1};
		row_sum  = {1'b0, row_q} + {6'd0, byte_s1};
		lit_dec  = lit_q - 8'd1;

		phase_d   = phase_q;
		col_d     = col_q;
		row_d     = row_q;
		held_d    = held_q;
		lit_d     = lit_q;
		pad_d     = pad_q;
		span_hit  = 1'b0;
		delta_cut = 1'b0;

		span_res             = '0;
		span_res.kind        = KIND_SPAN;
		span_res.row         = row_q[11:0];
		span_res.column      = col_q[11:0];
		span_res.pixel_value = byte_s1;
		span_res.last_of_run = !eos_s1;

		case (phase_q)
			PH_COUNT: begin
				if (row_q >= h) begin
					phase_d = PH_STOP;
				end else begin
					held_d  = byte_s1;
					phase_d = PH_VALUE;
				end
			end
			PH_VALUE: begin
				phase_d = PH_COUNT;
				held_d  = 8'd0;
				if (held_q != 8'd0) begin
					if (col_q < w) begin
						span_hit             = 1'b1;
						span_res.span_length = len;
						col_d                = col_q + {5'd0, len};
					end
				end else if (byte_s1 == 8'd0) begin
					col_d = '0;
					row_d = (({1'b0, row_q} + 14'd1) > {1'b0, h}) ? h : row_q + 13'd1;
				end else if (byte_s1 == 8'd1) begin
					phase_d = PH_STOP;
				end else if (byte_s1 == 8'd2) begin
					phase_d   = PH_DX;
					delta_cut = 1'b1;
				end else begin
					lit_d   = byte_s1;
					pad_d   = byte_s1[0];
					phase_d = PH_LIT;
				end
			end
			PH_DX: begin
				col_d     = (col_sum > {1'b0, w}) ? w : col_sum[DimW-1:0];
				phase_d   = PH_DY;
				delta_cut = 1'b1;
			end
			PH_DY: begin
				row_d   = (row_sum > {1'b0, h}) ? h : row_sum[DimW-1:0];
				phase_d = PH_COUNT;
			end
			PH_LIT: begin
				if (col_q < w) begin
					span_hit             = 1'b1;
					span_res.span_length = 8'd1;
					col_d                = col_q + 13'd1;
				end
				lit_d = lit_dec;
				if (lit_dec == 8'd0) begin
					phase_d = pad_q ? PH_PAD : PH_COUNT;
				end
			end
			PH_PAD: begin
				pad_d   = 1'b0;
				phase_d = PH_COUNT;
			end
			default: begin
				phase_d = PH_STOP;
			end
		endcase

		fin_res             = '0;
		fin_res.kind        = delta_cut ? KIND_DELTA_CUT : KIND_OK;
		fin_res.last_of_run = 1'b1;

		if (eos_s1) begin
			phase_d = PH_COUNT;
			col_d   = '0;
			row_d   = '0;
			held_d  = 8'd0;
			lit_d   = 8'd0;
			pad_d   = 1'b0;
		end

		push.cnt  = 2'(span_hit) + 2'(eos_s1);
		push.res0 = span_hit ? span_res : fin_res;
		push.res1 = fin_res;
		if (!advance) begin
			push.cnt = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			col_q   <= '0;
			row_q   <= '0;
			held_q  <= 8'd0;
			lit_q   <= 8'd0;
			pad_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			col_q   <= col_d;
			row_q   <= row_d;
			held_q  <= held_d;
			lit_q   <= lit_d;
			pad_q   <= pad_d;
		end
	end

endmodule
`default_nettype wire

// ----- src/brle_outq.sv -----
// Four-entry result queue taking up to two results per cycle.
`default_nettype none
module brle_outq (
	input  wire              clk,
	input  wire              arst_n,
	input  brle_pkg::push_t  push,
	output logic             space_ok,
	output logic             out_valid,
	input  wire              out_ready,
	output brle_pkg::result_t head
);
	import brle_pkg::*;

	result_t    q_mem [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 3'd0);
	assign pop       = out_valid && out_ready;
	assign space_ok  = (count_q <= 3'd2);
	assign head      = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			q_mem[wr_ptr_q] <= push.res0;
		end
		if (push.cnt == 2'd2) begin
			q_mem[wr_ptr_q + 2'd1] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.cnt;
			rd_ptr_q <= rd_ptr_q + 2'(pop);
			count_q  <= count_q + 3'(push.cnt) - 3'(pop);
		end
	end

endmodule
`default_nettype wire

// ----- src/bmp_rle8_decoder.sv -----
// Top level of the BMP RLE8 decoder: config registers, parser and result queue.
// Accepts one compressed byte per cycle on a valid/ready channel and returns
// pixel spans and a finish beat on a second valid/ready channel. The results of
// a byte pass through the input register, then the parse logic, which writes them
// into the result queue once it has room; throughput is one byte per cycle while
// results are taken. The byte marked end_of_stream yields an extra finish beat,
// so the queue absorbs up to two beats per byte and input stalls only when it is
// nearly full. Width and height registers sit at byte addresses 0 and 4; the user
// must write them only while the decoder is idle, which the block does not enforce.
`default_nettype none
module bmp_rle8_decoder (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       psel,
	input  wire                       penable,
	input  wire                       pwrite,
	input  wire [brle_pkg::AddrW-1:0] paddr,
	input  wire [31:0]                pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire [7:0]                 byte_in,
	input  wire                       end_of_stream,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic [1:0]                kind,
	output logic [11:0]               row,
	output logic [11:0]               column,
	output logic [7:0]                span_length,
	output logic [7:0]                pixel_value,
	output logic                      last_of_run
);
	import brle_pkg::*;

	cfg_t    cfg;
	push_t   push;
	logic    space_ok;
	result_t head;

	brle_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	brle_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte_in       (byte_in),
		.end_of_stream (end_of_stream),
		.space_ok      (space_ok),
		.push          (push)
	);

	brle_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind        = head.kind;
	assign row         = head.row;
	assign column      = head.column;
	assign span_length = head.span_length;
	assign pixel_value = head.pixel_value;
	assign last_of_run = head.last_of_run;

endmodule
`default_nettype wire
